// ===== sv/srpp_pkg.sv =====
// ----------------------------------------------------------------------------
// srpp_pkg
// Shared types and constants for the sensor reply packet parser.
// ----------------------------------------------------------------------------
package srpp_pkg;

    localparam logic [7:0] HDR_BYTE0 = 8'hEF;
    localparam logic [7:0] HDR_BYTE1 = 8'h01;

    // packet positions counted from the first header byte
    localparam int POS_ID      = 6;
    localparam int POS_LEN_LO  = 8;
    localparam int POS_CONFIRM = 9;
    localparam int POS_WORD_HI = 10;
    localparam int POS_WORD_LO = 11;

    localparam logic [8:0] TICK_SAT = 9'h1FF;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_ABORT = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_CHECKSUM = 3'd1,
        ST_TIMEOUT  = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_ABORTED  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_HEAD = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] rx_byte;
        logic [7:0] max_ticks;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [6:0]  byte_count;
        logic [7:0]  packet_id;
        logic [7:0]  confirm_code;
        logic [15:0] reply_word;
        logic [15:0] length_field;
    } t_result;

endpackage

// ===== sv/srpp_in_stage.sv =====
// ----------------------------------------------------------------------------
// srpp_in_stage
// Input register: holds one request until the parser core takes it.
// ----------------------------------------------------------------------------
module srpp_in_stage
    import srpp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_advance,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== sv/srpp_core.sv =====
// ----------------------------------------------------------------------------
// srpp_core
// Packet state and single-pass update: header hunt, field capture,
// checksum, tick limit and end-of-transaction report.
// ----------------------------------------------------------------------------
module srpp_core
    import srpp_pkg::*;
#(
    parameter int MAX_BYTES = 80
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    output logic    o_res_valid,
    output t_result o_res
);

    localparam int IW = $clog2(MAX_BYTES + 1);
    localparam logic [IW-1:0] IDX_MAX = IW'(MAX_BYTES);

    logic          r_active,   n_active;
    t_phase        r_phase,    n_phase;
    logic [IW-1:0] r_idx,      n_idx;
    logic [15:0]   r_sum,      n_sum;
    logic [15:0]   r_len,      n_len;
    logic          r_len_ok,   n_len_ok;
    logic [7:0]    r_prev,     n_prev;
    logic [7:0]    r_id,       n_id;
    logic [7:0]    r_confirm,  n_confirm;
    logic [15:0]   r_word,     n_word;
    logic [8:0]    r_ticks,    n_ticks;
    logic [7:0]    r_limit,    n_limit;

    logic          res_valid;
    t_status       res_status;
    logic [7:0]    b;
    logic [IW-1:0] idx_inc;
    logic [15:0]   net_sum;
    logic [15:0]   got_sum;
    logic          at_end;

    assign b       = i_item.rx_byte;
    assign idx_inc = r_idx + IW'(1);
    assign got_sum = {r_prev, b};

    always_comb begin
        n_active   = r_active;
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_sum      = r_sum;
        n_len      = r_len;
        n_len_ok   = r_len_ok;
        n_prev     = r_prev;
        n_id       = r_id;
        n_confirm  = r_confirm;
        n_word     = r_word;
        n_ticks    = r_ticks;
        n_limit    = r_limit;
        res_valid  = 1'b0;
        res_status = ST_OK;
        net_sum    = '0;
        at_end     = 1'b0;

        if (i_step) begin
            if (i_item.cmd == CMD_START) begin
                n_active  = 1'b1;
                n_phase   = PH_HUNT;
                n_idx     = '0;
                n_sum     = '0;
                n_len     = '0;
                n_len_ok  = 1'b0;
                n_prev    = '0;
                n_id      = '0;
                n_confirm = '0;
                n_word    = '0;
                n_ticks   = '0;
                n_limit   = i_item.max_ticks;
            end else if (r_active) begin
                unique case (i_item.cmd)
                    CMD_BYTE: begin
                        n_prev = b;
                        if (r_phase == PH_DATA) begin
                            n_idx = idx_inc;
                            if (idx_inc >= IW'(POS_ID)) begin
                                n_sum = r_sum + {8'd0, b};
                            end
                            if (idx_inc == IW'(POS_ID)) begin
                                n_id = b;
                            end
                            if (idx_inc == IW'(POS_LEN_LO)) begin
                                n_len    = {r_prev, b};
                                n_len_ok = 1'b1;
                            end
                            if (idx_inc == IW'(POS_CONFIRM)) begin
                                n_confirm = b;
                            end
                            if (idx_inc == IW'(POS_WORD_HI)) begin
                                n_word[15:8] = b;
                            end
                            if (idx_inc == IW'(POS_WORD_LO)) begin
                                n_word[7:0] = b;
                            end
                            // checksum bytes were summed too, take them back out
                            net_sum = n_sum - {8'd0, r_prev} - {8'd0, b};
                            at_end  = n_len_ok && ({{(17-IW){1'b0}}, idx_inc} ==
                                                   ({1'b0, n_len} + 17'd8));
                            if (at_end) begin
                                res_valid  = 1'b1;
                                res_status = (net_sum == got_sum) ? ST_OK : ST_CHECKSUM;
                            end else if (idx_inc >= IDX_MAX) begin
                                res_valid  = 1'b1;
                                res_status = ST_OVERFLOW;
                            end
                        end else begin
                            // 0xef always restarts the header while hunting
                            if (b == HDR_BYTE0) begin
                                n_phase = PH_HEAD;
                                n_idx   = '0;
                            end else if (r_phase == PH_HEAD) begin
                                if (b == HDR_BYTE1) begin
                                    n_phase = PH_DATA;
                                    n_idx   = IW'(1);
                                end else begin
                                    n_phase = PH_HUNT;
                                    n_idx   = '0;
                                end
                            end
                        end
                    end
                    CMD_TICK: begin
                        if (r_ticks != TICK_SAT) begin
                            n_ticks = r_ticks + 9'd1;
                        end
                        if (n_ticks > {1'b0, r_limit}) begin
                            res_valid  = 1'b1;
                            res_status = ST_TIMEOUT;
                        end
                    end
                    default: begin
                        res_valid  = 1'b1;
                        res_status = ST_ABORTED;
                    end
                endcase
                if (res_valid) begin
                    n_active = 1'b0;
                end
            end
        end
    end

    assign o_res_valid         = res_valid;
    assign o_res.status        = res_status;
    assign o_res.byte_count    = 7'(n_idx);
    assign o_res.packet_id     = n_id;
    assign o_res.confirm_code  = n_confirm;
    assign o_res.reply_word    = n_word;
    assign o_res.length_field  = n_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_phase   <= PH_HUNT;
            r_idx     <= '0;
            r_sum     <= '0;
            r_len     <= '0;
            r_len_ok  <= 1'b0;
            r_prev    <= '0;
            r_id      <= '0;
            r_confirm <= '0;
            r_word    <= '0;
            r_ticks   <= '0;
            r_limit   <= '0;
        end else begin
            r_active  <= n_active;
            r_phase   <= n_phase;
            r_idx     <= n_idx;
            r_sum     <= n_sum;
            r_len     <= n_len;
            r_len_ok  <= n_len_ok;
            r_prev    <= n_prev;
            r_id      <= n_id;
            r_confirm <= n_confirm;
            r_word    <= n_word;
            r_ticks   <= n_ticks;
            r_limit   <= n_limit;
        end
    end

endmodule

// ===== sv/srpp_out_stage.sv =====
// ----------------------------------------------------------------------------
// srpp_out_stage
// Result register: holds one report until the downstream side takes it.
// ----------------------------------------------------------------------------
module srpp_out_stage
    import srpp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== sv/sensor_reply_packet_parser.sv =====
// ----------------------------------------------------------------------------
// sensor_reply_packet_parser
// Parser for the reply packet of a serial sensor module.
// ----------------------------------------------------------------------------
// Takes one request per clock: start (latches the tick limit), received byte,
// timer tick or abort. Bytes hunt for the 0xef 0x01 header, then fill the
// address, packet id, length, payload and a 16-bit checksum summed from the
// id onward. One report leaves when a transaction ends: ok, checksum error,
// timeout, overflow at MAX_BYTES, or abort. Each request passes an input
// register and the parser logic into a result register. The block sustains
// one request per cycle while reports are taken; a stall on the result side
// holds back the input after one waiting report and one waiting request.
module sensor_reply_packet_parser
    import srpp_pkg::*;
#(
    parameter int MAX_BYTES = 80
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // rx_byte, max_ticks
    input  logic [1:0]  s_axis_tuser,  // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // byte_count, packet_id, confirm_code,
                                       // reply_word, length_field, zero pad
    output logic [2:0]  m_axis_tuser   // status
);

    t_item   in_item;
    t_item   core_item;
    logic    core_valid;
    logic    out_free;
    logic    advance;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign in_item.cmd       = t_cmd'(s_axis_tuser);
    assign in_item.rx_byte   = s_axis_tdata[7:0];
    assign in_item.max_ticks = s_axis_tdata[15:8];

    assign advance = core_valid && out_free;

    srpp_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (core_valid),
        .o_item    (core_item)
    );

    srpp_core #(
        .MAX_BYTES (MAX_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_item      (core_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    srpp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tuser = out_res.status;
    assign m_axis_tdata = {1'b0, out_res.length_field, out_res.reply_word,
                           out_res.confirm_code, out_res.packet_id,
                           out_res.byte_count};

endmodule
